// File: rtl/bult_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the bounded unordered list table.
package bult_pkg;

    // Width of one stored list value.
    localparam int DATA_W = 32;

    // Width of the entry count, the capacity register and the scan index.
    localparam int CNT_W = 5;

    // Largest value that the capacity register can hold.
    localparam int CNT_MAX = 31;

    // Capacity after reset.
    localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

    // Request kinds.
    typedef enum logic [1:0] {
        KIND_INSERT  = 2'd0,
        KIND_REMOVE  = 2'd1,
        KIND_SEARCH  = 2'd2,
        KIND_REPLACE = 2'd3
    } kind_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FINISH
    } state_t;

endpackage

// File: rtl/bult_mem.sv
`timescale 1ns / 1ps
// Entry storage: one write port, one read port with registered read data.
module bult_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [bult_pkg::DATA_W-1:0] wdata,
    input  logic [AW-1:0]              raddr,
    output logic [bult_pkg::DATA_W-1:0] rdata
);

    logic [bult_pkg::DATA_W-1:0] mem [DEPTH];
    logic [bult_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/bult_ctrl.sv
`timescale 1ns / 1ps
// Request sequencer: insert, linear scan, shift-down remove and result register.
module bult_ctrl #(
    parameter int AW = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [bult_pkg::CNT_W-1:0]  limit,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  kind,
    input  logic [bult_pkg::DATA_W-1:0] value,
    input  logic [bult_pkg::DATA_W-1:0] new_value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  status,
    output logic [bult_pkg::CNT_W-1:0]  count,
    output logic                        mem_we,
    output logic [AW-1:0]               mem_waddr,
    output logic [bult_pkg::DATA_W-1:0] mem_wdata,
    output logic [AW-1:0]               mem_raddr,
    input  logic [bult_pkg::DATA_W-1:0] mem_rdata
);

    bult_pkg::state_t              state_reg, state_next;
    bult_pkg::kind_t               kind_reg, kind_next;
    logic [bult_pkg::DATA_W-1:0]   val_reg, val_next;
    logic [bult_pkg::DATA_W-1:0]   nval_reg, nval_next;
    logic [bult_pkg::CNT_W-1:0]    idx_reg, idx_next;
    logic [bult_pkg::CNT_W-1:0]    used_reg, used_next;
    bult_pkg::status_t             st_reg, st_next;
    logic                          out_valid_reg, out_valid_next;
    bult_pkg::status_t             out_status_reg, out_status_next;
    logic [bult_pkg::CNT_W-1:0]    out_count_reg, out_count_next;
    logic [bult_pkg::CNT_W:0]      idx_plus1;

    assign idx_plus1 = {1'b0, idx_reg} + {{bult_pkg::CNT_W{1'b0}}, 1'b1};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bult_pkg::S_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        val_reg        <= val_next;
        nval_reg       <= nval_next;
        idx_reg        <= idx_next;
        st_reg         <= st_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        val_next        = val_reg;
        nval_next       = nval_reg;
        idx_next        = idx_reg;
        used_next       = used_reg;
        st_next         = st_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        mem_we          = 1'b0;
        mem_waddr       = AW'(idx_reg);
        mem_wdata       = val_reg;
        mem_raddr       = AW'(idx_reg);
        in_ready        = (state_reg == bult_pkg::S_IDLE);

        // The result register empties on its own handshake; a finishing
        // request below may refill it in the same cycle.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            bult_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next  = bult_pkg::kind_t'(kind);
                    val_next   = value;
                    nval_next  = new_value;
                    state_next = bult_pkg::S_START;
                end
            end
            bult_pkg::S_START:
            begin
                idx_next = '0;
                if (kind_reg == bult_pkg::KIND_INSERT)
                begin
                    if (used_reg < limit)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(used_reg);
                        used_next = used_reg + bult_pkg::CNT_W'(1);
                        st_next   = bult_pkg::ST_DONE;
                    end
                    else
                    begin
                        st_next = bult_pkg::ST_FULL;
                    end
                    state_next = bult_pkg::S_FINISH;
                end
                else
                begin
                    state_next = bult_pkg::S_SCAN_RD;
                end
            end
            bult_pkg::S_SCAN_RD:
            begin
                if (idx_reg >= used_reg)
                begin
                    st_next    = bult_pkg::ST_MISSING;
                    state_next = bult_pkg::S_FINISH;
                end
                else
                begin
                    state_next = bult_pkg::S_SCAN_CMP;
                end
            end
            bult_pkg::S_SCAN_CMP:
            begin
                if (mem_rdata == val_reg)
                begin
                    st_next = bult_pkg::ST_DONE;
                    unique case (kind_reg)
                        bult_pkg::KIND_REMOVE:
                        begin
                            state_next = bult_pkg::S_SHIFT_RD;
                        end
                        bult_pkg::KIND_REPLACE:
                        begin
                            mem_we     = 1'b1;
                            mem_wdata  = nval_reg;
                            state_next = bult_pkg::S_FINISH;
                        end
                        bult_pkg::KIND_SEARCH,
                        bult_pkg::KIND_INSERT:
                        begin
                            state_next = bult_pkg::S_FINISH;
                        end
                    endcase
                end
                else
                begin
                    idx_next   = idx_plus1[bult_pkg::CNT_W-1:0];
                    state_next = bult_pkg::S_SCAN_RD;
                end
            end
            bult_pkg::S_SHIFT_RD:
            begin
                if (idx_plus1 >= {1'b0, used_reg})
                begin
                    used_next  = used_reg - bult_pkg::CNT_W'(1);
                    state_next = bult_pkg::S_FINISH;
                end
                else
                begin
                    mem_raddr  = AW'(idx_plus1[bult_pkg::CNT_W-1:0]);
                    state_next = bult_pkg::S_SHIFT_WR;
                end
            end
            bult_pkg::S_SHIFT_WR:
            begin
                mem_we     = 1'b1;
                mem_wdata  = mem_rdata;
                idx_next   = idx_plus1[bult_pkg::CNT_W-1:0];
                state_next = bult_pkg::S_SHIFT_RD;
            end
            bult_pkg::S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = st_reg;
                    out_count_next  = used_reg;
                    state_next      = bult_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bult_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign count     = out_count_reg;

endmodule

// File: rtl/bounded_unordered_list_table.sv
`timescale 1ns / 1ps
// Top level of the bounded unordered list table.
//
//   Channel   Signals                          Direction  Transfer rule
//   in        in_valid/in_ready, kind, value,  sink       valid & ready at clk rise
//             new_value
//   out       out_valid/out_ready, status,     source     valid & ready at clk rise
//             count
//   cfg       cfg_wr_en, cfg_wr_data           sink       cfg_wr_en at clk rise
//
// One request is handled at a time by a sequencer around a single-port-read,
// single-port-write entry memory with registered read data. An insert writes
// at the count and finishes. Search, replace and remove scan the entries in
// order, reading one entry and then comparing it; a remove that finds its
// value then shifts each later entry down by one and lowers the count.
// The result sits in an output register, so the sequencer returns to idle and
// takes the next transaction while a result waits; it stalls only if a second
// result is ready before the first one is taken.
// Reset clears the count, the capacity (to 16) and the sequencer state; the
// entry memory is not cleared since only entries below the count are read.
module bounded_unordered_list_table #(
    parameter int DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [31:0] value,
    input  logic [31:0] new_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [4:0]  count
);

    // Address width of the entry memory; a single-entry memory still gets one bit.
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // The count can never exceed what the capacity register can express.
    localparam int LIM_MAX = (DEPTH < bult_pkg::CNT_MAX) ? DEPTH : bult_pkg::CNT_MAX;
    localparam logic [bult_pkg::CNT_W-1:0] LIM_MAX_C = bult_pkg::CNT_W'(LIM_MAX);

    logic [bult_pkg::CNT_W-1:0]  cap_reg;
    logic [bult_pkg::CNT_W-1:0]  limit;
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [bult_pkg::DATA_W-1:0] mem_wdata;
    logic [AW-1:0]               mem_raddr;
    logic [bult_pkg::DATA_W-1:0] mem_rdata;

    // Capacity register; user writes only while no request is in flight; unchecked.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= bult_pkg::CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            cap_reg <= cfg_wr_data;
        end
    end

    // The effective limit is the smaller of the capacity and the memory depth.
    assign limit = (cap_reg > LIM_MAX_C) ? LIM_MAX_C : cap_reg;

    bult_ctrl #(
        .AW (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .limit     (limit),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .value     (value),
        .new_value (new_value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .count     (count),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    bult_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
